@@ hw/rtl/tiled_background_pixel_fetch_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tiled background pixel fetch core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TILED_BACKGROUND_PIXEL_FETCH_CORE_ASSERT_SVH
`define TILED_BACKGROUND_PIXEL_FETCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define TBPF_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("tbpf assertion failed");
// Check that a condition never holds outside reset
`define TBPF_ASSERT_NEVER(lbl, clk_i, rst_ni, cond) \
	`TBPF_ASSERT(lbl, clk_i, rst_ni, !(cond))
`else
`define TBPF_ASSERT(lbl, clk_i, rst_ni, prop)
`define TBPF_ASSERT_NEVER(lbl, clk_i, rst_ni, cond)
`endif
`endif

@@ hw/rtl/tbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Tiled background pixel fetch package
// Shared types, codes and constants for the pixel fetch core.
// ----------------------------------------------------------------------------
package tbpf_pkg;

	// Storage defaults
	localparam int unsigned VIDEO_HALFWORDS_DEF = 65536;
	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	// Working byte address width (holds unwrapped bitmap offsets)
	localparam int unsigned ADDR_W = 20;
	localparam int unsigned MAP_AW = 17;

	// Address constants
	localparam int unsigned SCREEN_BLOCK = 'h800;
	localparam int unsigned FRAME_OFFSET = 'hA000;
	localparam int unsigned BMP3_STRIDE  = 480;
	localparam int unsigned BMP4_STRIDE  = 240;
	localparam int unsigned BMP5_STRIDE  = 320;
	localparam int unsigned WIDE_W       = 240;
	localparam int unsigned WIDE_H       = 160;
	localparam int unsigned SMALL_W      = 160;
	localparam int unsigned SMALL_H      = 128;

	// Display mode codes
	localparam logic [2:0] MODE_TEXT  = 3'd0;
	localparam logic [2:0] MODE_MIXED = 3'd1;
	localparam logic [2:0] MODE_ROT   = 3'd2;
	localparam logic [2:0] MODE_BMP16 = 3'd3;
	localparam logic [2:0] MODE_BMP8  = 3'd4;

	// Input commands
	typedef enum logic [1:0] {
		CMD_WR_VIDEO   = 2'd0,
		CMD_WR_PALETTE = 2'd1,
		CMD_RENDER     = 2'd2
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DISPLAY_MODE = 2'd0,
		REG_BG_CONTROL   = 2'd1,
		REG_BG_INDEX     = 2'd2,
		REG_FRAME_SELECT = 2'd3
	} reg_idx_t;

	// Pixel lookup kinds
	typedef enum logic [1:0] {
		KIND_TEXT   = 2'd0,
		KIND_ROT    = 2'd1,
		KIND_DIRECT = 2'd2,
		KIND_PAL8   = 2'd3
	} pix_kind_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR = 3'd0,
		S_IDLE  = 3'd1,
		S_WRAP1 = 3'd2,
		S_DATA1 = 3'd3,
		S_WRAP2 = 3'd4,
		S_DATA2 = 3'd5,
		S_PAL   = 3'd6
	} state_t;

	typedef struct packed {
		logic [2:0]  display_mode;
		logic [15:0] bg_control;
		logic [1:0]  bg_index;
		logic        frame_select;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [15:0] write_data;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
	} req_t;

	typedef struct packed {
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [MAP_AW-1:0] map_address;
		logic              in_range;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;
		logic wr_video;
		logic wr_palette;
		logic load_pix;
		logic wrap_sub;
		logic vid_rd;
		logic first_data;
		logic second_data;
		logic pal_done;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic      addr_ge;
		logic      clr_last;
		pix_kind_t kind;
	} dp_stat_t;

endpackage

@@ hw/rtl/tbpf_cfg.sv @@
// ----------------------------------------------------------------------------
// Tiled background pixel fetch configuration registers
// APB-style register file for mode, background control, index and frame.
// ----------------------------------------------------------------------------
module tbpf_cfg
	import tbpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write registers on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DISPLAY_MODE: begin
					cfg_q.display_mode <= pwdata[2:0];
				end
				REG_BG_CONTROL: begin
					cfg_q.bg_control <= pwdata[15:0];
				end
				REG_BG_INDEX: begin
					cfg_q.bg_index <= pwdata[1:0];
				end
				REG_FRAME_SELECT: begin
					cfg_q.frame_select <= pwdata[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		case (reg_sel)
			REG_DISPLAY_MODE: prdata = {29'd0, cfg_q.display_mode};
			REG_BG_CONTROL:   prdata = {16'd0, cfg_q.bg_control};
			REG_BG_INDEX:     prdata = {30'd0, cfg_q.bg_index};
			REG_FRAME_SELECT: prdata = {31'd0, cfg_q.frame_select};
			default:          prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/tbpf_dp.sv @@
// ----------------------------------------------------------------------------
// Tiled background pixel fetch datapath
// Video and palette memories, address formation, wrap unit and result register.
// ----------------------------------------------------------------------------
`include "tiled_background_pixel_fetch_core_assert.svh"

module tbpf_dp
	import tbpf_pkg::*;
#(
	parameter int unsigned VIDEO_HALFWORDS = VIDEO_HALFWORDS_DEF,
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output rsp_t     rsp,
	output logic     done
);

	localparam int unsigned VIDX_W = $clog2(VIDEO_HALFWORDS);
	localparam int unsigned PIDX_W = $clog2(PALETTE_ENTRIES);
	localparam logic [ADDR_W-1:0] WRAP_BYTES = ADDR_W'(2 * VIDEO_HALFWORDS);

	// Memories
	logic [15:0] vid_mem [VIDEO_HALFWORDS];
	logic [15:0] pal_mem [PALETTE_ENTRIES];

	// Control registers
	logic [VIDX_W-1:0] clr_q;
	logic              done_q;

	// Payload registers
	logic [9:0]        x_q;
	logic [9:0]        y_q;
	pix_kind_t         kind_q;
	logic              inside_q;
	logic              eight_q;
	logic [3:0]        bank_q;
	logic              nib_hi_q;
	logic [ADDR_W-1:0] addr_q;
	logic [MAP_AW-1:0] maddr_q;
	logic [15:0]       vid_rdata_q;
	logic [15:0]       pal_rdata_q;
	rsp_t              rsp_q;

	// Combinational nets
	logic [15:0]       ctl;
	logic [ADDR_W-1:0] mapbase;
	logic [ADDR_W-1:0] charbase;
	logic [ADDR_W-1:0] first_addr;
	pix_kind_t         first_kind;
	logic              first_inside;
	logic [16:0]       wr_wrap;
	logic [VIDX_W-1:0] vid_widx;
	logic [15:0]       vid_wdata;
	logic              vid_we;
	logic [PIDX_W-1:0] pal_widx;
	logic [15:0]       pal_wdata;
	logic              pal_we;
	logic [7:0]        rd_byte;
	logic [ADDR_W-1:0] tile_addr;
	logic [2:0]        tx;
	logic [2:0]        ty;
	logic              pal_re;
	logic [PIDX_W-1:0] pal_ridx;
	logic              out_load;
	logic [15:0]       colour;

	assign ctl      = cfg.bg_control;
	assign mapbase  = ADDR_W'({ctl[12:8], 11'd0});
	assign charbase = ADDR_W'({ctl[3:2], 14'd0});

	// Decode lookup kind, first address and range for the incoming pixel
	always_comb begin
		logic [9:0]        x;
		logic [9:0]        y;
		logic [ADDR_W-1:0] blk_x;
		logic [ADDR_W-1:0] blk_y;
		logic [2:0]        rot_shift;
		logic [ADDR_W-1:0] frame_off;
		x = req.pixel_x;
		y = req.pixel_y;
		blk_x = (x[9:8] != 2'd0) ? ADDR_W'(SCREEN_BLOCK) : '0;
		blk_y = '0;
		if (ctl[15] && (y[9:8] != 2'd0)) begin
			blk_y = ctl[14] ? ADDR_W'(2 * SCREEN_BLOCK) : ADDR_W'(SCREEN_BLOCK);
		end
		rot_shift = 3'd4 + {1'b0, ctl[15:14]};
		frame_off = cfg.frame_select ? ADDR_W'(FRAME_OFFSET) : '0;
		case (cfg.display_mode)
			MODE_TEXT: first_kind = KIND_TEXT;
			MODE_MIXED: first_kind = (cfg.bg_index < 2'd2) ? KIND_TEXT : KIND_ROT;
			MODE_ROT: first_kind = KIND_ROT;
			MODE_BMP8: first_kind = KIND_PAL8;
			default: first_kind = KIND_DIRECT;
		endcase
		case (first_kind)
			KIND_TEXT: begin
				first_addr = mapbase + blk_y + blk_x + ADDR_W'({x[7:3], 1'b0})
					+ ADDR_W'({y[7:3], 6'd0});
				first_inside = ((x[9:8] == 2'd0) || (!x[9] && ctl[14]))
					&& ((y[9:8] == 2'd0) || (!y[9] && ctl[15]));
			end
			KIND_ROT: begin
				first_addr = mapbase + ADDR_W'(x[9:3]) + (ADDR_W'(y[9:3]) << rot_shift);
				first_inside = ({1'b0, x} < (11'd128 << ctl[15:14]))
					&& ({1'b0, y} < (11'd128 << ctl[15:14]));
			end
			KIND_PAL8: begin
				first_addr = frame_off + ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(BMP4_STRIDE);
				first_inside = (x < 10'(WIDE_W)) && (y < 10'(WIDE_H));
			end
			default: begin
				if (cfg.display_mode == MODE_BMP16) begin
					first_addr = ADDR_W'({x, 1'b0}) + ADDR_W'(y) * ADDR_W'(BMP3_STRIDE);
					first_inside = (x < 10'(WIDE_W)) && (y < 10'(WIDE_H));
				end else begin
					first_addr = frame_off + ADDR_W'({x, 1'b0})
						+ ADDR_W'(y) * ADDR_W'(BMP5_STRIDE);
					first_inside = (x < 10'(SMALL_W)) && (y < 10'(SMALL_H));
				end
			end
		endcase
	end

	// Wrap the halfword index of a video write
	always_comb begin
		wr_wrap = {1'b0, req.address};
		if (wr_wrap >= 17'(VIDEO_HALFWORDS)) begin
			wr_wrap = wr_wrap - 17'(VIDEO_HALFWORDS);
		end
	end

	// Select write ports: clearing pass or write items
	always_comb begin
		vid_we    = cmd.clr_step || cmd.wr_video;
		vid_widx  = cmd.clr_step ? clr_q : wr_wrap[VIDX_W-1:0];
		vid_wdata = cmd.clr_step ? 16'd0 : req.write_data;
		pal_we    = (cmd.clr_step && (clr_q < VIDX_W'(PALETTE_ENTRIES))) || cmd.wr_palette;
		pal_widx  = cmd.clr_step ? clr_q[PIDX_W-1:0] : req.address[PIDX_W-1:0];
		pal_wdata = cmd.clr_step ? 16'd0 : req.write_data;
	end

	// Form the tile data address from the map entry
	always_comb begin
		rd_byte = addr_q[0] ? vid_rdata_q[15:8] : vid_rdata_q[7:0];
		tx = x_q[2:0] ^ {3{vid_rdata_q[10]}};
		ty = y_q[2:0] ^ {3{vid_rdata_q[11]}};
		if (kind_q == KIND_ROT) begin
			tile_addr = charbase + ADDR_W'({rd_byte, y_q[2:0], x_q[2:0]});
		end else if (ctl[7]) begin
			tile_addr = charbase + ADDR_W'({vid_rdata_q[9:0], ty, tx});
		end else begin
			tile_addr = charbase + ADDR_W'({vid_rdata_q[9:0], ty, tx[2:1]});
		end
	end

	// Select the palette read index
	always_comb begin
		pal_re = (cmd.first_data && (kind_q == KIND_PAL8)) || cmd.second_data;
		if (cmd.second_data && !eight_q) begin
			pal_ridx = PIDX_W'({bank_q, nib_hi_q ? rd_byte[7:4] : rd_byte[3:0]});
		end else begin
			pal_ridx = PIDX_W'(rd_byte);
		end
	end

	// Write video memory
	always_ff @(posedge clk) begin
		if (vid_we) begin
			vid_mem[vid_widx] <= vid_wdata;
		end
	end

	// Read video memory
	always_ff @(posedge clk) begin
		if (cmd.vid_rd) begin
			vid_rdata_q <= vid_mem[addr_q[VIDX_W:1]];
		end
	end

	// Write palette memory
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_widx] <= pal_wdata;
		end
	end

	// Read palette memory
	always_ff @(posedge clk) begin
		if (pal_re) begin
			pal_rdata_q <= pal_mem[pal_ridx];
		end
	end

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Hold pixel context and step the working address
	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			x_q      <= req.pixel_x;
			y_q      <= req.pixel_y;
			kind_q   <= first_kind;
			inside_q <= first_inside;
			addr_q   <= first_addr;
		end else if (cmd.wrap_sub) begin
			addr_q <= addr_q - WRAP_BYTES;
		end else if (cmd.first_data) begin
			maddr_q <= addr_q[MAP_AW-1:0];
			if ((kind_q == KIND_TEXT) || (kind_q == KIND_ROT)) begin
				addr_q   <= tile_addr;
				eight_q  <= (kind_q == KIND_ROT) || ctl[7];
				bank_q   <= vid_rdata_q[15:12];
				nib_hi_q <= tx[0];
			end
		end
	end

	// Load the result register
	assign out_load = (cmd.first_data && (kind_q == KIND_DIRECT)) || cmd.pal_done;

	always_comb begin
		colour = cmd.pal_done ? pal_rdata_q : vid_rdata_q;
		if (!inside_q) begin
			colour = 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.red         <= {colour[4:0], 3'd0};
			rsp_q.green       <= {colour[9:5], 3'd0};
			rsp_q.blue        <= {colour[14:10], 3'd0};
			rsp_q.map_address <= cmd.first_data ? addr_q[MAP_AW-1:0] : maddr_q;
			rsp_q.in_range    <= inside_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= out_load;
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

	assign stat.addr_ge  = addr_q >= WRAP_BYTES;
	assign stat.clr_last = clr_q == VIDX_W'(VIDEO_HALFWORDS - 1);
	assign stat.kind     = kind_q;

	`TBPF_ASSERT(a_rd_in_range, clk, arst_n, cmd.vid_rd |-> (addr_q < WRAP_BYTES))
	`TBPF_ASSERT(a_outside_black, clk, arst_n, (done_q && !rsp_q.in_range) |-> ((rsp_q.red == 8'd0) && (rsp_q.green == 8'd0) && (rsp_q.blue == 8'd0)))

endmodule

@@ hw/rtl/tbpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tiled background pixel fetch controller
// Sequences clearing, writes and the dependent reads of a pixel lookup.
// ----------------------------------------------------------------------------
`include "tiled_background_pixel_fetch_core_assert.svh"

module tbpf_ctrl
	import tbpf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  dp_stat_t   stat,
	output ctl_cmd_t   cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_WR_VIDEO: cmd.wr_video = 1'b1;
						CMD_WR_PALETTE: cmd.wr_palette = 1'b1;
						CMD_RENDER: begin
							cmd.load_pix = 1'b1;
							state_d = S_WRAP1;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WRAP1: begin
				if (stat.addr_ge) begin
					cmd.wrap_sub = 1'b1;
				end else begin
					cmd.vid_rd = 1'b1;
					state_d = S_DATA1;
				end
			end
			S_DATA1: begin
				cmd.first_data = 1'b1;
				case (stat.kind)
					KIND_PAL8: state_d = S_PAL;
					KIND_DIRECT: state_d = S_IDLE;
					default: state_d = S_WRAP2;
				endcase
			end
			S_WRAP2: begin
				if (stat.addr_ge) begin
					cmd.wrap_sub = 1'b1;
				end else begin
					cmd.vid_rd = 1'b1;
					state_d = S_DATA2;
				end
			end
			S_DATA2: begin
				cmd.second_data = 1'b1;
				state_d = S_PAL;
			end
			S_PAL: begin
				cmd.pal_done = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;

	`TBPF_ASSERT_NEVER(a_sub_needs_ge, clk, arst_n, cmd.wrap_sub && !stat.addr_ge)
	`TBPF_ASSERT(a_read_then_data, clk, arst_n, cmd.vid_rd |=> (cmd.first_data || cmd.second_data))
	`TBPF_ASSERT(a_pal_after_read, clk, arst_n, cmd.pal_done |-> $past(cmd.first_data || cmd.second_data))

endmodule

@@ hw/rtl/tiled_background_pixel_fetch_core.sv @@
// ----------------------------------------------------------------------------
// Tiled background pixel fetch core
// Text, rotation and bitmap background pixel lookup with video and palette RAM.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start high and busy low. Command
//   write video and write palette store write_data and give no result; an
//   unused command is dropped. A render command yields one result beat:
//   done is high for exactly one cycle with rsp valid, and the receiver
//   cannot stall it. A new item may be started in the cycle done is shown.
//   A render walks a chain of dependent reads: map entry, tile data and
//   palette entry for text and rotation maps; pixel and palette entry for
//   a paletted bitmap; the pixel alone for bitmap direct colour. Before each
//   video read the wrap unit subtracts 2*VIDEO_HALFWORDS from the address
//   while it is not below that bound. No new item is taken until the end.
//   After reset busy stays high while both memories are swept to zero;
//   register writes are taken throughout. The user must write registers
//   over the APB-style port only while no render is in flight; the block
//   itself does not enforce this.
// ----------------------------------------------------------------------------
module tiled_background_pixel_fetch_core
	import tbpf_pkg::*;
#(
	parameter int unsigned VIDEO_HALFWORDS = VIDEO_HALFWORDS_DEF,
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg;
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Register file
	tbpf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	tbpf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (req.command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// Memories and address logic
	tbpf_dp #(
		.VIDEO_HALFWORDS (VIDEO_HALFWORDS),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp),
		.done   (done)
	);

endmodule
